### design/saq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saq_pkg
// Shared constants for the shortest-arc quaternion pipeline.
// ----------------------------------------------------------------------------
package saq_pkg;
  localparam int IN_BITS_DEF   = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int OUT_BITS      = 16;
  localparam int SQ_BITS       = 64;   // radicand width
  localparam int RT_BITS       = 32;   // root width
  localparam int DIV_BITS      = 62;   // dividend magnitude width (Q60 + guard)
  localparam int QB            = 32;   // quotient width
  localparam logic signed [31:0] OPP_LIM = -32'sd1072668082; // -(2^30 - 1073742)
  localparam logic [63:0] SMALL_AXIS = 64'd11529215046068470;
endpackage

### design/shortest_arc_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_arc_quaternion
// Rotation quaternion that turns a start vector onto a destination vector.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request carries start_x/y/z and dest_x/y/z, packed in in_tdata.
//   out_* : result carries quat_w/x/y/z in out_tdata and status in out_tuser.
//   One pair is accepted per cycle. Every stage advances when the output
//   register is free or taken, so throughput is one item per cycle.
//   The chain runs through normalize shift, sum of squares,
//   bit-serial-per-stage square root (one root bit per stage), restoring
//   division (one quotient bit per stage), dot and cross products,
//   second root and divide.
//   A stall of out_tready freezes the whole pipe; nothing is lost or
//   repeated. Synchronous active-low reset clears all valid bits.
//   A zero-length vector returns zeros with status = 1.
// ----------------------------------------------------------------------------
module shortest_arc_quaternion
  import saq_pkg::*;
#(
  parameter int IN_BITS   = IN_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // start_x, start_y, start_z, dest_x, dest_y, dest_z (low to high), zero fill
  input  logic [((6*IN_BITS+7)/8)*8-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // quat_w, quat_x, quat_y, quat_z (low to high)
  output logic [63:0]              out_tdata,
  // status
  output logic                     out_tuser
);
  localparam int SH = 30 - FRAC_BITS;

  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // -------------------------------------------------------------- helpers
  function automatic logic [29:0] norm30(input logic [IN_BITS-1:0] m,
                                         input logic [IN_BITS-1:0] big);
    int p;
    logic [63:0] t;
    p = 0;
    for (int i = 0; i < IN_BITS; i++) if (big[i]) p = i;
    t = {{(64-IN_BITS){1'b0}}, m};
    if (p <= 29) t = t << (29 - p);
    else t = t >> (p - 29);
    return t[29:0];
  endfunction

  // ------------------------------------------------------- pipeline state
  typedef struct packed {
    logic               err;
    logic [2:0]         sa, sd;        // signs
    logic [29:0]        ma0, ma1, ma2, md0, md1, md2;
  } s0_t;

  // stage A: unpack, magnitudes, normalize shift
  s0_t a_r;
  logic a_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_tvalid;
    if (adv) begin : ua
      logic signed [IN_BITS-1:0] r [6];
      logic [IN_BITS-1:0] m [6];
      logic [IN_BITS-1:0] bs, bd;
      for (int i = 0; i < 6; i++) begin
        r[i] = in_tdata[i*IN_BITS +: IN_BITS];
        m[i] = r[i][IN_BITS-1] ? IN_BITS'(-r[i]) : IN_BITS'(r[i]);
      end
      bs = m[0] | m[1] | m[2];
      bd = m[3] | m[4] | m[5];
      a_r.err <= (bs == '0) || (bd == '0);
      a_r.sa  <= {r[2][IN_BITS-1], r[1][IN_BITS-1], r[0][IN_BITS-1]};
      a_r.sd  <= {r[5][IN_BITS-1], r[4][IN_BITS-1], r[3][IN_BITS-1]};
      a_r.ma0 <= norm30(m[0], bs); a_r.ma1 <= norm30(m[1], bs);
      a_r.ma2 <= norm30(m[2], bs);
      a_r.md0 <= norm30(m[3], bd); a_r.md1 <= norm30(m[4], bd);
      a_r.md2 <= norm30(m[5], bd);
    end
  end

  // stage B: squares
  s0_t b_r;
  logic b_v_r;
  logic [59:0] bsq_r [6];
  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
    if (adv) begin
      b_r <= a_r;
      bsq_r[0] <= a_r.ma0 * a_r.ma0; bsq_r[1] <= a_r.ma1 * a_r.ma1;
      bsq_r[2] <= a_r.ma2 * a_r.ma2; bsq_r[3] <= a_r.md0 * a_r.md0;
      bsq_r[4] <= a_r.md1 * a_r.md1; bsq_r[5] <= a_r.md2 * a_r.md2;
    end
  end

  // stage C: sums
  s0_t c_r;
  logic c_v_r;
  logic [63:0] c_ls_r, c_ld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= b_v_r;
    if (adv) begin
      c_r <= b_r;
      c_ls_r <= 64'(bsq_r[0]) + 64'(bsq_r[1]) + 64'(bsq_r[2]);
      c_ld_r <= 64'(bsq_r[3]) + 64'(bsq_r[4]) + 64'(bsq_r[5]);
    end
  end

  // stage group D: two square roots, one result bit per stage
  s0_t          dq_r  [RT_BITS+1];
  logic         dv_r  [RT_BITS+1];
  logic [63:0]  dxs_r [RT_BITS+1], dxd_r [RT_BITS+1];
  logic [63:0]  drs_r [RT_BITS+1], drd_r [RT_BITS+1];
  always_comb begin
    dq_r[0] = c_r; dv_r[0] = c_v_r;
    dxs_r[0] = c_ls_r; dxd_r[0] = c_ld_r; drs_r[0] = '0; drd_r[0] = '0;
  end
  for (genvar k = 0; k < RT_BITS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    s0_t q_r; logic v_r; logic [63:0] xs_r, xd_r, rs_r, rd_r;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (adv) v_r <= dv_r[k];
      if (adv) begin
        q_r <= dq_r[k];
        if (dxs_r[k] >= drs_r[k] + BIT) begin
          xs_r <= dxs_r[k] - (drs_r[k] + BIT); rs_r <= (drs_r[k] >> 1) + BIT;
        end else begin
          xs_r <= dxs_r[k]; rs_r <= drs_r[k] >> 1;
        end
        if (dxd_r[k] >= drd_r[k] + BIT) begin
          xd_r <= dxd_r[k] - (drd_r[k] + BIT); rd_r <= (drd_r[k] >> 1) + BIT;
        end else begin
          xd_r <= dxd_r[k]; rd_r <= drd_r[k] >> 1;
        end
      end
    end
    always_comb begin
      dq_r[k+1] = q_r; dv_r[k+1] = v_r;
      dxs_r[k+1] = xs_r; dxd_r[k+1] = xd_r; drs_r[k+1] = rs_r; drd_r[k+1] = rd_r;
    end
  end

  // stage group E: six rounded divisions m<<30 / len, one bit per stage
  typedef struct packed {
    logic err;
    logic [2:0] sa, sd;
    logic [31:0] la, ld;
  } e_t;
  e_t          eq_r [QB+1];
  logic        ev_r [QB+1];
  logic [62:0] er_r [QB+1][6];   // partial remainder
  logic [61:0] en_r [QB+1][6];   // dividend bits yet to shift in
  logic [QB-1:0] eo_r [QB+1][6];
  always_comb begin
    eq_r[0].err = dq_r[RT_BITS].err;
    eq_r[0].sa = dq_r[RT_BITS].sa; eq_r[0].sd = dq_r[RT_BITS].sd;
    eq_r[0].la = drs_r[RT_BITS][31:0]; eq_r[0].ld = drd_r[RT_BITS][31:0];
    ev_r[0] = dv_r[RT_BITS];
    // dividend = (m<<30) + len/2, top bits beyond QB quotient bits start in rem
    en_r[0][0] = {2'b00, dq_r[RT_BITS].ma0, 30'd0} + 62'(drs_r[RT_BITS][31:1]);
    en_r[0][1] = {2'b00, dq_r[RT_BITS].ma1, 30'd0} + 62'(drs_r[RT_BITS][31:1]);
    en_r[0][2] = {2'b00, dq_r[RT_BITS].ma2, 30'd0} + 62'(drs_r[RT_BITS][31:1]);
    en_r[0][3] = {2'b00, dq_r[RT_BITS].md0, 30'd0} + 62'(drd_r[RT_BITS][31:1]);
    en_r[0][4] = {2'b00, dq_r[RT_BITS].md1, 30'd0} + 62'(drd_r[RT_BITS][31:1]);
    en_r[0][5] = {2'b00, dq_r[RT_BITS].md2, 30'd0} + 62'(drd_r[RT_BITS][31:1]);
    for (int j = 0; j < 6; j++) begin
      er_r[0][j] = 63'(en_r[0][j] >> QB);
      eo_r[0][j] = '0;
    end
  end
  for (genvar k = 0; k < QB; k++) begin : g_div1
    e_t q_r; logic v_r;
    logic [62:0] r_r [6]; logic [61:0] n_r [6]; logic [QB-1:0] o_r [6];
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (adv) v_r <= ev_r[k];
      if (adv) begin : st
        logic [63:0] t;
        logic [31:0] d;
        q_r <= eq_r[k];
        for (int j = 0; j < 6; j++) begin
          d = (j < 3) ? eq_r[k].la : eq_r[k].ld;
          t = {er_r[k][j], en_r[k][j][QB-1-k]};
          if (t >= 64'(d)) begin
            r_r[j] <= 63'(t - 64'(d)); o_r[j] <= {eo_r[k][j][QB-2:0], 1'b1};
          end else begin
            r_r[j] <= t[62:0]; o_r[j] <= {eo_r[k][j][QB-2:0], 1'b0};
          end
          n_r[j] <= en_r[k][j];
        end
      end
    end
    always_comb begin
      eq_r[k+1] = q_r; ev_r[k+1] = v_r;
      for (int j = 0; j < 6; j++) begin
        er_r[k+1][j] = r_r[j]; en_r[k+1][j] = n_r[j]; eo_r[k+1][j] = o_r[j];
      end
    end
  end

  // stage F: signed unit components
  logic f_v_r, f_err_r;
  logic signed [31:0] fa_r [3], fb_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (adv) f_v_r <= ev_r[QB];
    if (adv) begin
      f_err_r <= eq_r[QB].err;
      for (int j = 0; j < 3; j++) begin
        fa_r[j] <= eq_r[QB].sa[j] ? -$signed(eo_r[QB][j]) : $signed(eo_r[QB][j]);
        fb_r[j] <= eq_r[QB].sd[j] ? -$signed(eo_r[QB][j+3]) : $signed(eo_r[QB][j+3]);
      end
    end
  end

  // stage G: products
  logic g_v_r, g_err_r;
  logic signed [31:0] ga_r [3];
  logic signed [63:0] gp_r [9];  // aa(3) dot(3); cross pairs are in gx_r
  logic signed [63:0] gx_r [6];
  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0;
    else if (adv) g_v_r <= f_v_r;
    if (adv) begin
      g_err_r <= f_err_r;
      ga_r <= fa_r;
      gp_r[0] <= fa_r[0] * fa_r[0]; gp_r[1] <= fa_r[1] * fa_r[1];
      gp_r[2] <= fa_r[2] * fa_r[2];
      gp_r[3] <= fa_r[0] * fb_r[0]; gp_r[4] <= fa_r[1] * fb_r[1];
      gp_r[5] <= fa_r[2] * fb_r[2];
      gx_r[0] <= fa_r[1] * fb_r[2]; gx_r[1] <= fa_r[2] * fb_r[1];
      gx_r[2] <= fa_r[2] * fb_r[0]; gx_r[3] <= fa_r[0] * fb_r[2];
      gx_r[4] <= fa_r[0] * fb_r[1]; gx_r[5] <= fa_r[1] * fb_r[0];
    end
  end

  // stage H: dot sum, cross, opposite axis choice
  logic h_v_r, h_err_r;
  logic signed [63:0] h_dot_r;
  logic signed [63:0] h_cr_r [3];
  logic signed [31:0] h_ax_r [3];
  logic [63:0] h_l2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) h_v_r <= 1'b0;
    else if (adv) h_v_r <= g_v_r;
    if (adv) begin
      h_err_r <= g_err_r;
      h_dot_r <= gp_r[3] + gp_r[4] + gp_r[5];
      h_cr_r[0] <= gx_r[0] - gx_r[1];
      h_cr_r[1] <= gx_r[2] - gx_r[3];
      h_cr_r[2] <= gx_r[4] - gx_r[5];
      if (64'(gp_r[0]) + 64'(gp_r[1]) < SMALL_AXIS) begin
        h_ax_r[0] <= '0; h_ax_r[1] <= -ga_r[2]; h_ax_r[2] <= ga_r[1];
        h_l2_r <= 64'(gp_r[2]) + 64'(gp_r[1]);
      end else begin
        h_ax_r[0] <= -ga_r[1]; h_ax_r[1] <= ga_r[0]; h_ax_r[2] <= '0;
        h_l2_r <= 64'(gp_r[0]) + 64'(gp_r[1]);
      end
    end
  end

  // stage I: c, select radicand and numerators
  logic i_v_r, i_err_r, i_opp_r;
  logic [63:0] i_rad_r;
  logic signed [63:0] i_num_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0;
    else if (adv) i_v_r <= h_v_r;
    if (adv) begin : si
      logic [63:0] mg;
      logic signed [63:0] c;
      mg = h_dot_r[63] ? 64'(-h_dot_r) : 64'(h_dot_r);
      mg = (mg + (64'd1 << 29)) >> 30;
      c = h_dot_r[63] ? -$signed(mg) : $signed(mg);
      i_err_r <= h_err_r;
      i_opp_r <= c < 64'(OPP_LIM);
      if (c < 64'(OPP_LIM)) begin
        i_rad_r <= h_l2_r;
        for (int j = 0; j < 3; j++) i_num_r[j] <= 64'(h_ax_r[j]) <<< 30;
      end else begin
        i_rad_r <= 64'((64'd1 << 30) + 64'(c)) << 31;
        i_num_r <= h_cr_r;
      end
    end
  end

  // stage group J: second root
  typedef struct packed {
    logic err, opp;
    logic [2:0] sg;
    logic [61:0] n0, n1, n2;
  } j_t;
  j_t jq_r [RT_BITS+1];
  logic jv_r [RT_BITS+1];
  logic [63:0] jx_r [RT_BITS+1], jr_r [RT_BITS+1];
  always_comb begin
    jq_r[0].err = i_err_r; jq_r[0].opp = i_opp_r;
    jq_r[0].sg = {i_num_r[2][63], i_num_r[1][63], i_num_r[0][63]};
    jq_r[0].n0 = 62'(i_num_r[0][63] ? -i_num_r[0] : i_num_r[0]);
    jq_r[0].n1 = 62'(i_num_r[1][63] ? -i_num_r[1] : i_num_r[1]);
    jq_r[0].n2 = 62'(i_num_r[2][63] ? -i_num_r[2] : i_num_r[2]);
    jv_r[0] = i_v_r; jx_r[0] = i_rad_r; jr_r[0] = '0;
  end
  for (genvar k = 0; k < RT_BITS; k++) begin : g_sqrt2
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    j_t q_r; logic v_r; logic [63:0] x_r, r_r;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (adv) v_r <= jv_r[k];
      if (adv) begin
        q_r <= jq_r[k];
        if (jx_r[k] >= jr_r[k] + BIT) begin
          x_r <= jx_r[k] - (jr_r[k] + BIT); r_r <= (jr_r[k] >> 1) + BIT;
        end else begin
          x_r <= jx_r[k]; r_r <= jr_r[k] >> 1;
        end
      end
    end
    always_comb begin
      jq_r[k+1] = q_r; jv_r[k+1] = v_r; jx_r[k+1] = x_r; jr_r[k+1] = r_r;
    end
  end

  // stage group K: three rounded divisions num / s
  typedef struct packed {
    logic err, opp;
    logic [2:0] sg;
    logic [31:0] s;
  } k_t;
  k_t kq_r [QB+1];
  logic kv_r [QB+1];
  logic [62:0] kr_r [QB+1][3];
  logic [62:0] kn_r [QB+1][3];
  logic [QB-1:0] ko_r [QB+1][3];
  always_comb begin
    kq_r[0].err = jq_r[RT_BITS].err; kq_r[0].opp = jq_r[RT_BITS].opp;
    kq_r[0].sg = jq_r[RT_BITS].sg; kq_r[0].s = jr_r[RT_BITS][31:0];
    kv_r[0] = jv_r[RT_BITS];
    kn_r[0][0] = 63'(jq_r[RT_BITS].n0) + 63'(jr_r[RT_BITS][31:1]);
    kn_r[0][1] = 63'(jq_r[RT_BITS].n1) + 63'(jr_r[RT_BITS][31:1]);
    kn_r[0][2] = 63'(jq_r[RT_BITS].n2) + 63'(jr_r[RT_BITS][31:1]);
    for (int j = 0; j < 3; j++) begin
      kr_r[0][j] = 63'(kn_r[0][j] >> QB);
      ko_r[0][j] = '0;
    end
  end
  for (genvar k = 0; k < QB; k++) begin : g_div2
    k_t q_r; logic v_r;
    logic [62:0] r_r [3], n_r [3]; logic [QB-1:0] o_r [3];
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (adv) v_r <= kv_r[k];
      if (adv) begin : st
        logic [63:0] t;
        q_r <= kq_r[k];
        for (int j = 0; j < 3; j++) begin
          t = {kr_r[k][j], kn_r[k][j][QB-1-k]};
          if (kq_r[k].s != '0 && t >= 64'(kq_r[k].s)) begin
            r_r[j] <= 63'(t - 64'(kq_r[k].s)); o_r[j] <= {ko_r[k][j][QB-2:0], 1'b1};
          end else begin
            r_r[j] <= t[62:0]; o_r[j] <= {ko_r[k][j][QB-2:0], 1'b0};
          end
          n_r[j] <= kn_r[k][j];
        end
      end
    end
    always_comb begin
      kq_r[k+1] = q_r; kv_r[k+1] = v_r;
      for (int j = 0; j < 3; j++) begin
        kr_r[k+1][j] = r_r[j]; kn_r[k+1][j] = n_r[j]; ko_r[k+1][j] = o_r[j];
      end
    end
  end

  // output stage: round to Q1.FRAC_BITS, saturate
  function automatic logic [OUT_BITS-1:0] to_out(input logic [QB-1:0] m,
                                                 input logic neg);
    logic [QB:0] q;
    logic [QB:0] lim;
    logic [OUT_BITS-1:0] v;
    lim = (QB+1)'(1) << FRAC_BITS;
    q = ((QB+1)'(m) + ((QB+1)'(1) << (SH-1))) >> SH;
    if (q > lim) q = lim;
    v = q[OUT_BITS-1:0];
    return neg ? OUT_BITS'(-v) : v;
  endfunction

  logic [63:0] out_tdata_r;
  logic out_tuser_r, out_tvalid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (adv) out_tvalid_r <= kv_r[QB];
    if (adv) begin : so
      logic [QB-1:0] w;
      w = kq_r[QB].opp ? '0 : QB'(kq_r[QB].s);
      out_tuser_r <= kq_r[QB].err;
      if (kq_r[QB].err) out_tdata_r <= '0;
      else begin
        // w = round(s/2) then to output: combined rounding as two steps
        out_tdata_r[15:0]  <= to_out(QB'((w + QB'(1)) >> 1), 1'b0);
        out_tdata_r[31:16] <= to_out(ko_r[QB][0], kq_r[QB].sg[0]);
        out_tdata_r[47:32] <= to_out(ko_r[QB][1], kq_r[QB].sg[1]);
        out_tdata_r[63:48] <= to_out(ko_r[QB][2], kq_r[QB].sg[2]);
      end
    end
  end
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ------------------------------------------------------------ checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result not zero");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives vector pairs through shortest_arc_quaternion and compares every
// quaternion and status against a bit-exact fixed-point predictor, under
// random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
  import saq_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] w, x, y, z;
    logic        err;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic out_tuser;

  quat_t quat_q[$];
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int mismatches = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_opposite = 0;
  int n_zero = 0;
  longint cycles = 0;

  shortest_arc_quaternion dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absv(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function automatic longint div_round(longint n, longint unsigned d);
    longint unsigned q;
    if (d == 0) return 0;
    q = (absv(n) + d / 2) / d;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint shr_round(longint v, int sh);
    longint unsigned q;
    if (sh == 0) return v;
    q = (absv(v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] q30_to_out(longint v);
    longint r, lim;
    r = shr_round(v, 30 - FB);
    lim = longint'(1) << FB;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  function automatic bit normalize(input longint raw[3], output longint n[3]);
    longint unsigned m[3], big, len;
    longint t;
    int up, dn;
    big = 0; up = 0; dn = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = absv(raw[i]);
      if (m[i] > big) big = m[i];
    end
    if (big == 0) return 1'b0;
    while (big < (64'd1 << 29)) begin big <<= 1; up++; end
    while (big >= (64'd1 << 30)) begin big >>= 1; dn++; end
    for (int i = 0; i < 3; i++) m[i] = (m[i] << up) >> dn;
    len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      t = longint'(m[i] << 30);
      n[i] = div_round(raw[i] < 0 ? -t : t, len);
    end
    return 1'b1;
  endfunction

  function automatic quat_t arc_quat(logic [95:0] d);
    longint rs[3], rd[3], a[3], b[3], q[4], ax[3], c;
    longint unsigned l2, len, s;
    longint t;
    quat_t r;
    for (int i = 0; i < 3; i++) begin
      rs[i] = longint'($signed(d[16*i +: 16]));
      rd[i] = longint'($signed(d[16*(i+3) +: 16]));
    end
    if (!normalize(rs, a) || !normalize(rd, b)) begin
      r = '0;
      r.err = 1'b1;
      n_zero++;
      return r;
    end
    c = shr_round(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 30);
    if (c < longint'(OPP_LIM)) begin
      n_opposite++;
      ax[0] = -a[1]; ax[1] = a[0]; ax[2] = 0;
      l2 = ax[0] * ax[0] + ax[1] * ax[1];
      if (l2 < SMALL_AXIS) begin
        ax[0] = 0; ax[1] = -a[2]; ax[2] = a[1];
      end
      len = root64(ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2]);
      q[0] = 0;
      for (int i = 0; i < 3; i++) begin
        t = longint'(absv(ax[i]) << 30);
        q[1+i] = div_round(ax[i] < 0 ? -t : t, len);
      end
    end else begin
      s = root64(longint'((longint'(1) << 30) + c) << 31);
      q[0] = shr_round(longint'(s), 1);
      q[1] = div_round(a[1] * b[2] - a[2] * b[1], s);
      q[2] = div_round(a[2] * b[0] - a[0] * b[2], s);
      q[3] = div_round(a[0] * b[1] - a[1] * b[0], s);
    end
    r.w = q30_to_out(q[0]);
    r.x = q30_to_out(q[1]);
    r.y = q30_to_out(q[2]);
    r.z = q30_to_out(q[3]);
    r.err = 1'b0;
    return r;
  endfunction

  // ---------------- driving ----------------
  task automatic send_pair(input logic signed [15:0] sx, sy, sz, dx, dy, dz);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {dz, dy, dx, sz, sy, sx};
    in_tvalid <= 1'b1;
    quat_q.push_back(arc_quat({dz, dy, dx, sz, sy, sx}));
    n_sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    go_idle();
    while (quat_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_tready <= (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    mismatches++;
    $display("mismatch %s on result %0d: got %h want %h", what, n_checked, got, want);
  endtask

  always @(posedge clk) begin
    quat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (quat_q.size() == 0) begin
        mismatches++;
        $display("unexpected result %h/%b", out_tdata, out_tuser);
      end else begin
        want = quat_q.pop_front();
        if (out_tdata[15:0] !== want.w) report("quat_w", out_tdata[15:0], want.w);
        if (out_tdata[31:16] !== want.x) report("quat_x", out_tdata[31:16], want.x);
        if (out_tdata[47:32] !== want.y) report("quat_y", out_tdata[47:32], want.y);
        if (out_tdata[63:48] !== want.z) report("quat_z", out_tdata[63:48], want.z);
        if (out_tuser !== want.err) report("status", 16'(out_tuser), 16'(want.err));
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", quat_q.size());
      $display("[shortest_arc_quaternion] ERROR");
      $finish;
    end
  end

  // ---------------- tests ----------------
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'($urandom_range(7)) - 16'd3;
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(1, 0, 0, 1, 0, 0);
    send_pair(1, 0, 0, -1, 0, 0);
    send_pair(0, 0, 1, 0, 0, -1);
    send_pair(0, 1, 0, 0, -1, 0);
    send_pair(3, 4, 0, -3, -4, 1);
    send_pair(0, 0, 0, 1, 2, 3);
    send_pair(1, 2, 3, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(-32768, -32768, -32768, 32767, 32767, 32767);
    send_pair(32767, -32768, 32767, -32768, 32767, -32768);
    send_pair(-32768, 0, 0, 32767, 0, 0);
    send_pair(32767, 32767, 32767, 32767, 32767, 32767);
    send_pair(1, 1, 1, -1, -1, -1);
    send_pair(100, 1, 20000, -100, -1, -20000);
    send_pair(1, 0, 0, -1000, 30, 0);
    send_pair(16'hffff, 16'haaaa, 16'h5555, 16'h0001, 16'hfffe, 16'h1234);
    send_pair(0, 0, -5, 0, 0, 7);
  endtask

  task automatic test_random(input int count);
    logic [15:0] sx, sy, sz, k;
    for (int i = 0; i < count; i++) begin
      sx = rand_comp(); sy = rand_comp(); sz = rand_comp();
      case ($urandom_range(9))
        // nearly opposite pair: negated start plus a small nudge
        0, 1, 2: begin
          k = 16'($urandom_range(3));
          send_pair(sx, sy, sz, -$signed(sx) + $signed(k), -$signed(sy), -$signed(sz));
        end
        3: send_pair(sx, sy, sz, sx, sy, sz);
        4: send_pair(0, 0, sz, 0, 0, -$signed(sz) | 16'h1);
        default: send_pair(sx, sy, sz, rand_comp(), rand_comp(), rand_comp());
      endcase
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    src_idle_pct = 33; snk_idle_pct = 85;
    test_random(300);
    src_idle_pct = 85; snk_idle_pct = 33;
    test_random(300);
    src_idle_pct = 0; snk_idle_pct = 0;
    test_random(300);
    drain();
    repeat (200) @(posedge clk);
    $display("sent %0d vector pairs, checked %0d results", n_sent, n_checked);
    $display("near-opposite cases %0d, zero-length cases %0d", n_opposite, n_zero);
    if (mismatches == 0 && quat_q.size() == 0) begin
      $display("[shortest_arc_quaternion] OK");
    end else begin
      $display("[shortest_arc_quaternion] ERROR");
    end
    $finish;
  end
endmodule

### files.f
design/saq_pkg.sv
design/shortest_arc_quaternion.sv
tb/testbench.sv
